// File: hw/rtl/pif_pkg.sv
// ----------------------------------------------------------------------------
// pif_pkg
// Shared constants, types and helpers of the integer format interpreter.
// ----------------------------------------------------------------------------
package pif_pkg;

  localparam int MAX_FIELD   = 60;
  localparam int SPEC_DEPTH  = 16;
  localparam int MAX_DIGITS  = 22;
  localparam int MAX_OUT     = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int CONV_STEPS  = 64;
  localparam int NUM_REGS    = 3;

  localparam int NUM_W      = $clog2(MAX_FIELD + 1);
  localparam int SPEC_IDX_W = $clog2(SPEC_DEPTH);
  localparam int SPEC_LEN_W = $clog2(SPEC_DEPTH + 1);
  localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int OUT_W      = $clog2(MAX_OUT + 1);
  localparam int CONV_W     = $clog2(CONV_STEPS);
  localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int SPAN_W     = $clog2(2 + 3 * MAX_FIELD + MAX_DIGITS + SPEC_DEPTH + 1);
  localparam int PADDR_W    = $clog2(4 * NUM_REGS);

  localparam logic [1:0] REG_INT_IS_32     = 2'd0;
  localparam logic [1:0] REG_LONG_IS_64    = 2'd1;
  localparam logic [1:0] REG_POINTER_IS_32 = 2'd2;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_L       = 8'h6c;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_P       = 8'h70;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_O       = 8'h6f;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_I       = 8'h69;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef enum logic [1:0] {RADIX_8, RADIX_10, RADIX_16} radix_t;
  typedef enum logic [1:0] {BITS_16, BITS_32, BITS_64} bits_t;
  typedef enum logic [1:0] {SIGN_NONE, SIGN_SPACE, SIGN_PLUS} sign_mode_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_CONV, BK_COUNT, BK_LAYOUT, BK_SPAN, BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic int_is_32;
    logic long_is_64;
    logic pointer_is_32;
  } cfg_t;

  typedef struct packed {
    logic                             is_num;
    logic                             bad;
    radix_t                           radix;
    logic                             upper;
    logic [63:0]                      value;
    logic [SPEC_DEPTH-1:0][7:0]       text;
    logic [SPEC_LEN_W-1:0]            slen;
    logic [NUM_W-1:0]                 width;
    logic [NUM_W-1:0]                 prec;
    logic                             use_prec;
    logic                             left;
    logic                             zero_first;
    logic [1:0]                       plen;
    logic [7:0]                       pre0;
    logic [7:0]                       pre1;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [63:0] mask_bits(logic [63:0] v, bits_t b);
    case (b)
      BITS_16: mask_bits = {48'd0, v[15:0]};
      BITS_32: mask_bits = {32'd0, v[31:0]};
      default: mask_bits = v;
    endcase
  endfunction

  function automatic logic top_bit(logic [63:0] v, bits_t b);
    case (b)
      BITS_16: top_bit = v[15];
      BITS_32: top_bit = v[31];
      default: top_bit = v[63];
    endcase
  endfunction

  function automatic logic [NUM_W-1:0] sat_field(logic [63:0] v);
    sat_field = (v > 64'(MAX_FIELD)) ? NUM_W'(MAX_FIELD) : v[NUM_W-1:0];
  endfunction

endpackage

// File: hw/rtl/pif_in_if.sv
// ----------------------------------------------------------------------------
// pif_in_if
// Format character channel: one character and its argument word per beat.
// ----------------------------------------------------------------------------
interface pif_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  fmt_char;
  logic [63:0] arg_value;

  modport source (output valid, output fmt_char, output arg_value, input ready);
  modport sink   (input valid, input fmt_char, input arg_value, output ready);
endinterface

// File: hw/rtl/pif_out_if.sv
// ----------------------------------------------------------------------------
// pif_out_if
// Text channel: one emitted character with its flags and running count.
// ----------------------------------------------------------------------------
interface pif_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        last;
  logic        bad_spec;
  logic [31:0] total_count;

  modport source (output valid, output out_char, output last, output bad_spec,
                  output total_count, input ready);
  modport sink   (input valid, input out_char, input last, input bad_spec,
                  input total_count, output ready);
endinterface

// File: hw/rtl/pif_front.sv
// ----------------------------------------------------------------------------
// pif_front
// Specifier parser: tracks flags, width and precision, and turns every
// character that produces text into a job for the emitter.
// ----------------------------------------------------------------------------
module pif_front (
  input  logic          clk,
  input  logic          rst,
  input  pif_pkg::cfg_t cfg,
  pif_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output pif_pkg::job_t job
);
  import pif_pkg::*;

  logic                       in_spec, in_spec_next;
  logic [NUM_W-1:0]           pending, pending_next;
  logic [NUM_W-1:0]           fwidth, fwidth_next;
  logic                       fl_long, fl_long_next;
  logic                       fl_llong, fl_llong_next;
  logic                       fl_alt, fl_alt_next;
  logic                       fl_left, fl_left_next;
  logic                       fl_zero, fl_zero_next;
  logic                       have_num, have_num_next;
  logic                       have_prec, have_prec_next;
  sign_mode_t                 sign_mode, sign_mode_next;
  logic [SPEC_DEPTH-1:0][7:0] spec_text, spec_text_next;
  logic [SPEC_LEN_W-1:0]      spec_len, spec_len_next;

  logic accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    logic [7:0]  ch;
    logic [63:0] arg;
    bits_t       ibits;
    bits_t       nbits;
    bits_t       ubits;
    logic        done;
    logic        is_number;
    logic        signed_conv;
    logic [63:0] u;
    logic [63:0] star_v;
    logic        neg;
    logic        zero_val;
    logic        alt_eff;
    logic [7:0]  sgn;
    logic        have_sgn;
    logic [9:0]  acc;

    ch          = in_ch.fmt_char;
    arg         = in_ch.arg_value;
    ibits       = cfg.int_is_32 ? BITS_32 : BITS_16;
    nbits       = fl_llong ? BITS_64 : (fl_long ? (cfg.long_is_64 ? BITS_64 : BITS_32) : ibits);
    ubits       = nbits;
    done        = 1'b1;
    is_number   = 1'b0;
    signed_conv = 1'b0;
    u           = '0;
    star_v      = '0;
    neg         = 1'b0;
    zero_val    = 1'b0;
    alt_eff     = fl_alt;
    sgn         = CH_SPACE;
    have_sgn    = 1'b0;
    acc         = '0;

    in_spec_next   = in_spec;
    pending_next   = pending;
    fwidth_next    = fwidth;
    fl_long_next   = fl_long;
    fl_llong_next  = fl_llong;
    fl_alt_next    = fl_alt;
    fl_left_next   = fl_left;
    fl_zero_next   = fl_zero;
    have_num_next  = have_num;
    have_prec_next = have_prec;
    sign_mode_next = sign_mode;
    spec_text_next = spec_text;
    spec_len_next  = spec_len;

    push           = 1'b0;
    job            = '0;
    job.radix      = RADIX_10;
    job.slen       = SPEC_LEN_W'(1);
    job.text[0]    = ch;

    case (sign_mode)
      SIGN_PLUS:  begin sgn = CH_PLUS;  have_sgn = 1'b1; end
      SIGN_SPACE: begin sgn = CH_SPACE; have_sgn = 1'b1; end
      default:    begin sgn = CH_SPACE; have_sgn = 1'b0; end
    endcase

    if (accept) begin
      if (!in_spec) begin
        if (ch == CH_PERCENT) begin
          in_spec_next   = 1'b1;
          pending_next   = '0;
          fwidth_next    = '0;
          fl_long_next   = 1'b0;
          fl_llong_next  = 1'b0;
          fl_alt_next    = 1'b0;
          fl_left_next   = 1'b0;
          fl_zero_next   = 1'b0;
          have_num_next  = 1'b0;
          have_prec_next = 1'b0;
          sign_mode_next = SIGN_NONE;
          spec_text_next[0] = CH_PERCENT;
          spec_len_next  = SPEC_LEN_W'(1);
        end else begin
          push = 1'b1;
        end
      end else begin
        if (spec_len < SPEC_LEN_W'(SPEC_DEPTH)) begin
          spec_text_next[spec_len[SPEC_IDX_W-1:0]] = ch;
          spec_len_next = spec_len + SPEC_LEN_W'(1);
        end
        case (ch)
          CH_PERCENT: begin
            push        = 1'b1;
            job.text[0] = CH_PERCENT;
          end
          CH_HASH: begin
            fl_alt_next = 1'b1;
            done        = 1'b0;
          end
          CH_L: begin
            if (fl_llong) begin
              push     = 1'b1;
              job.bad  = 1'b1;
              job.text = spec_text_next;
              job.slen = spec_len_next;
            end else begin
              if (fl_long) begin
                fl_long_next  = 1'b0;
                fl_llong_next = 1'b1;
              end else begin
                fl_long_next  = 1'b1;
              end
              done = 1'b0;
            end
          end
          CH_MINUS: begin
            fl_left_next = 1'b1;
            done         = 1'b0;
          end
          CH_PLUS: begin
            sign_mode_next = SIGN_PLUS;
            done           = 1'b0;
          end
          CH_SPACE: begin
            if (sign_mode != SIGN_PLUS) sign_mode_next = SIGN_SPACE;
            done = 1'b0;
          end
          CH_DOT: begin
            if (have_num) begin
              fwidth_next   = pending;
              pending_next  = '0;
              have_num_next = 1'b0;
            end
            have_prec_next = 1'b1;
            done           = 1'b0;
          end
          CH_STAR: begin
            star_v = mask_bits(arg, ibits);
            if (!top_bit(star_v, ibits)) begin
              pending_next = sat_field(star_v);
            end else if (have_prec) begin
              pending_next = '0;
            end else begin
              fl_left_next = 1'b1;
              pending_next = sat_field(mask_bits(64'd0 - star_v, ibits));
            end
            have_num_next = 1'b1;
            done          = 1'b0;
          end
          CH_C: begin
            push        = 1'b1;
            job.text[0] = arg[7:0];
            if (have_num || have_prec) begin
              job.plen       = have_sgn ? 2'd1 : 2'd0;
              job.pre0       = sgn;
              job.left       = fl_left;
              job.zero_first = fl_zero && !fl_left;
              if (have_prec) begin
                job.width = fwidth;
                job.slen  = (pending == '0) ? SPEC_LEN_W'(0) : SPEC_LEN_W'(1);
              end else begin
                job.width = pending;
              end
            end
          end
          CH_P: begin
            is_number = 1'b1;
            ubits     = cfg.pointer_is_32 ? BITS_32 : BITS_16;
            job.radix = RADIX_16;
            alt_eff   = (mask_bits(arg, ubits) != 64'd0);
          end
          CH_UPPER_X: begin
            is_number = 1'b1;
            job.radix = RADIX_16;
            job.upper = 1'b1;
          end
          CH_LOWER_X: begin
            is_number = 1'b1;
            job.radix = RADIX_16;
          end
          CH_O: begin
            is_number = 1'b1;
            job.radix = RADIX_8;
          end
          CH_D, CH_I: begin
            is_number   = 1'b1;
            signed_conv = 1'b1;
          end
          CH_U: begin
            is_number = 1'b1;
          end
          default: begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
              if (ch == CH_ZERO && pending == '0 && !have_prec) begin
                fl_zero_next = !fl_left;
              end else begin
                acc = 10'(pending) * 10'd10 + 10'(ch[3:0]);
                pending_next  = (acc > 10'(MAX_FIELD)) ? NUM_W'(MAX_FIELD) : acc[NUM_W-1:0];
                have_num_next = 1'b1;
              end
              done = 1'b0;
            end else begin
              push     = 1'b1;
              job.bad  = 1'b1;
              job.text = spec_text_next;
              job.slen = spec_len_next;
            end
          end
        endcase

        if (is_number) begin
          push     = 1'b1;
          job.is_num = 1'b1;
          u        = mask_bits(arg, ubits);
          neg      = top_bit(u, ubits);
          zero_val = (u == 64'd0);
          if (signed_conv && neg) begin
            u        = mask_bits(64'd0 - u, ubits);
            sgn      = CH_MINUS;
            have_sgn = 1'b1;
          end
          if (job.radix != RADIX_10) have_sgn = 1'b0;
          job.value = u;
          if (alt_eff && !zero_val && job.radix == RADIX_16) begin
            job.plen = 2'd2;
            job.pre0 = CH_ZERO;
            job.pre1 = job.upper ? CH_UPPER_X : CH_LOWER_X;
          end else if (alt_eff && !zero_val && job.radix == RADIX_8) begin
            job.plen = 2'd1;
            job.pre0 = CH_ZERO;
          end else if (have_sgn) begin
            job.plen = 2'd1;
            job.pre0 = sgn;
          end
          job.prec       = pending;
          job.use_prec   = have_prec;
          job.width      = (!have_prec && have_num) ? pending : fwidth;
          job.left       = fl_left;
          job.zero_first = fl_zero && !fl_left;
        end

        if (done) in_spec_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_spec   <= 1'b0;
      pending   <= '0;
      fwidth    <= '0;
      fl_long   <= 1'b0;
      fl_llong  <= 1'b0;
      fl_alt    <= 1'b0;
      fl_left   <= 1'b0;
      fl_zero   <= 1'b0;
      have_num  <= 1'b0;
      have_prec <= 1'b0;
      sign_mode <= SIGN_NONE;
      spec_len  <= '0;
    end else begin
      in_spec   <= in_spec_next;
      pending   <= pending_next;
      fwidth    <= fwidth_next;
      fl_long   <= fl_long_next;
      fl_llong  <= fl_llong_next;
      fl_alt    <= fl_alt_next;
      fl_left   <= fl_left_next;
      fl_zero   <= fl_zero_next;
      have_num  <= have_num_next;
      have_prec <= have_prec_next;
      sign_mode <= sign_mode_next;
      spec_len  <= spec_len_next;
    end
  end

  always_ff @(posedge clk) begin
    spec_text <= spec_text_next;
  end

endmodule

// File: hw/rtl/pif_queue.sv
// ----------------------------------------------------------------------------
// pif_queue
// Short job queue between parser and emitter.
// ----------------------------------------------------------------------------
module pif_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  pif_pkg::job_t          push_job,
  input  logic                   pop,
  output pif_pkg::job_t          head,
  output pif_pkg::queue_status_t status
);
  import pif_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_job;
  end

endmodule

// File: hw/rtl/pif_back.sv
// ----------------------------------------------------------------------------
// pif_back
// Emitter: converts the value to digits, lays out the padded field and
// sends it one character per beat through the output register.
// ----------------------------------------------------------------------------
module pif_back (
  input  logic                   clk,
  input  logic                   rst,
  input  pif_pkg::job_t          head,
  input  pif_pkg::queue_status_t q_status,
  output logic                   pop,
  pif_out_if.source              out_ch
);
  import pif_pkg::*;

  back_state_t state, state_next;

  job_t                         job;
  logic [MAX_DIGITS-1:0][3:0]   digits;
  logic [63:0]                  shreg;
  logic [CONV_W-1:0]            conv_cnt;
  logic [DIG_CNT_W-1:0]         nd;
  logic [SPAN_W-1:0]            seg_a, seg_f, seg_b, seg_z, seg_s, seg_t;
  logic [SPAN_W-1:0]            e1, e2, e3, e4, e5;
  logic [OUT_W-1:0]             total;
  logic [OUT_W-1:0]             pos;
  logic [31:0]                  emitted;

  logic                         slot_free;
  logic                         load_out;
  logic                         take_job;
  logic                         emit_last;
  logic [7:0]                   field_char;
  logic [MAX_DIGITS*4-1:0]      hex_bits;
  logic [MAX_DIGITS*3-1:0]      oct_bits;
  logic [MAX_DIGITS-1:0][3:0]   direct_digits;
  logic [MAX_DIGITS-1:0][3:0]   dabble_digits;
  logic [DIG_CNT_W-1:0]         nd_calc;

  assign slot_free = !out_ch.valid || out_ch.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          if (!head.is_num)                state_next = BK_LAYOUT;
          else if (head.radix == RADIX_10) state_next = BK_CONV;
          else                             state_next = BK_COUNT;
        end
      end
      BK_CONV:   if (conv_cnt == CONV_W'(CONV_STEPS - 1)) state_next = BK_COUNT;
      BK_COUNT:  state_next = BK_LAYOUT;
      BK_LAYOUT: state_next = BK_SPAN;
      BK_SPAN:   state_next = BK_EMIT;
      BK_EMIT: begin
        if (total == '0) state_next = BK_IDLE;
        else if (slot_free && emit_last) state_next = BK_IDLE;
      end
      default:   state_next = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    take_job = 1'b0;
    load_out = 1'b0;
    case (state)
      BK_IDLE: take_job = !q_status.empty;
      BK_EMIT: load_out = slot_free && (total != '0);
      default: begin
        take_job = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  assign pop = take_job;

  // hex and octal digits come straight from the bits
  always_comb begin
    hex_bits = (MAX_DIGITS*4)'(head.value);
    oct_bits = (MAX_DIGITS*3)'(head.value);
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (head.radix == RADIX_16) direct_digits[k] = hex_bits[4*k +: 4];
      else                        direct_digits[k] = {1'b0, oct_bits[3*k +: 3]};
    end
  end

  // one binary bit into the decimal digit register per cycle
  always_comb begin
    logic [MAX_DIGITS-1:0][3:0] corr;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      corr[k] = (digits[k] >= 4'd5) ? digits[k] + 4'd3 : digits[k];
    end
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (k == 0) dabble_digits[k] = {corr[k][2:0], shreg[63]};
      else        dabble_digits[k] = {corr[k][2:0], corr[k-1][3]};
    end
  end

  always_comb begin
    nd_calc = DIG_CNT_W'(1);
    for (int k = 1; k < MAX_DIGITS; k++) begin
      if (digits[k] != 4'd0) nd_calc = DIG_CNT_W'(k + 1);
    end
  end

  // character at the current field position
  always_comb begin
    logic [SPAN_W-1:0]    pe;
    logic [SPAN_W-1:0]    pidx;
    logic [SPAN_W-1:0]    bidx;
    logic [DIG_CNT_W-1:0] didx;
    logic [3:0]           dval;
    logic [7:0]           body;
    pe   = SPAN_W'(pos);
    pidx = pe - e2;
    bidx = pe - e4;
    didx = nd - DIG_CNT_W'(1) - bidx[DIG_CNT_W-1:0];
    dval = digits[didx[DIG_IDX_W-1:0]];
    if (dval < 4'd10)  body = CH_ZERO + 8'(dval);
    else if (job.upper) body = CH_UPPER_A + 8'(dval) - 8'd10;
    else               body = CH_LOWER_A + 8'(dval) - 8'd10;
    if (!job.is_num) body = job.text[bidx[SPEC_IDX_W-1:0]];

    if (pe < e1)      field_char = pe[0] ? job.pre1 : job.pre0;
    else if (pe < e2) field_char = job.zero_first ? CH_ZERO : CH_SPACE;
    else if (pe < e3) field_char = pidx[0] ? job.pre1 : job.pre0;
    else if (pe < e4) field_char = CH_ZERO;
    else if (pe < e5) field_char = body;
    else              field_char = CH_SPACE;
    emit_last = (pos == total - OUT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      out_ch.valid <= 1'b0;
      emitted      <= '0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_ch.valid <= 1'b1;
        emitted      <= emitted + 32'd1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [SPAN_W-1:0] w, pl, zr, s, w1, w2, used;
    w    = SPAN_W'(job.width);
    pl   = SPAN_W'(job.plen);
    s    = job.is_num ? SPAN_W'(nd) : SPAN_W'(job.slen);
    zr   = (job.is_num && job.use_prec && SPAN_W'(job.prec) > SPAN_W'(nd)) ?
           SPAN_W'(job.prec) - SPAN_W'(nd) : '0;
    w1   = (w >= pl) ? w - pl : '0;
    w2   = (w1 >= zr) ? w1 - zr : '0;
    used = pl + zr + s;

    case (state)
      BK_IDLE: begin
        if (take_job) begin
          job      <= head;
          shreg    <= head.value;
          conv_cnt <= '0;
          if (head.radix == RADIX_10) digits <= '0;
          else                        digits <= direct_digits;
        end
      end
      BK_CONV: begin
        digits   <= dabble_digits;
        shreg    <= {shreg[62:0], 1'b0};
        conv_cnt <= conv_cnt + CONV_W'(1);
      end
      BK_COUNT: nd <= nd_calc;
      BK_LAYOUT: begin
        seg_z <= zr;
        seg_s <= s;
        if (job.left) begin
          seg_a <= '0;
          seg_f <= '0;
          seg_b <= pl;
          seg_t <= (w > used) ? w - used : '0;
        end else begin
          seg_a <= job.zero_first ? pl : '0;
          seg_b <= job.zero_first ? '0 : pl;
          seg_f <= (w2 > s) ? w2 - s : '0;
          seg_t <= '0;
        end
      end
      BK_SPAN: begin
        e1  <= seg_a;
        e2  <= seg_a + seg_f;
        e3  <= seg_a + seg_f + seg_b;
        e4  <= seg_a + seg_f + seg_b + seg_z;
        e5  <= seg_a + seg_f + seg_b + seg_z + seg_s;
        pos <= '0;
      end
      BK_EMIT: begin
        if (load_out) pos <= pos + OUT_W'(1);
      end
      default: begin
        pos <= pos;
      end
    endcase

    // cap the field at the per-item output limit
    if (state == BK_SPAN) begin
      if ((seg_a + seg_f + seg_b + seg_z + seg_s + seg_t) > SPAN_W'(MAX_OUT)) begin
        total <= OUT_W'(MAX_OUT);
      end else begin
        total <= OUT_W'(seg_a + seg_f + seg_b + seg_z + seg_s + seg_t);
      end
    end

    if (load_out) begin
      out_ch.out_char    <= field_char;
      out_ch.last        <= emit_last;
      out_ch.bad_spec    <= job.bad;
      out_ch.total_count <= emitted + 32'd1;
    end
  end

endmodule

// File: hw/rtl/printf_integer_formatter.sv
// ----------------------------------------------------------------------------
// printf_integer_formatter
// Integer format interpreter: format characters in, text characters out.
// ----------------------------------------------------------------------------
// in_ch carries one format character and its argument word per beat; out_ch
// carries one text character per beat with last on the final character that
// an input caused, bad_spec on replayed specifier text and a running count.
// The APB port holds the int, long and pointer size registers; write them only
// while the block is idle.
// The parser takes one input per cycle while the two-entry job queue has room.
// Specifier flags and digits only update the parser state; with the emitter free,
// a character that produces text passes through the queue and the emitter's
// LAYOUT, SPAN and EMIT states to out_ch; a hex or octal field also passes COUNT.
// A decimal conversion first runs bit-serial binary to decimal shifting in CONV.
// A field then leaves at one character per cycle while out_ch is ready, and the
// emitter takes the next job only after the last character of the field.
// Reset clears the parser, the queue, the output register and the count.
// When out_ch stalls, the output register holds its character, the emitter
// waits, and the parser keeps taking input until the queue fills.
// ----------------------------------------------------------------------------
module printf_integer_formatter (
  input  logic                         clk,
  input  logic                         rst,
  pif_in_if.sink                       in_ch,
  pif_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pif_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import pif_pkg::*;

  cfg_t          cfg;
  logic          push;
  job_t          push_job;
  job_t          head;
  logic          pop;
  queue_status_t q_status;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_INT_IS_32:     cfg.int_is_32     <= pwdata[0];
        REG_LONG_IS_64:    cfg.long_is_64    <= pwdata[0];
        REG_POINTER_IS_32: cfg.pointer_is_32 <= pwdata[0];
        default:           cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INT_IS_32:     prdata = {31'd0, cfg.int_is_32};
      REG_LONG_IS_64:    prdata = {31'd0, cfg.long_is_64};
      REG_POINTER_IS_32: prdata = {31'd0, cfg.pointer_is_32};
      default:           prdata = '0;
    endcase
  end

  pif_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (q_status.full),
    .push   (push),
    .job    (push_job)
  );

  pif_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  pif_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// File: hw/rtl/pif_checker.sv
// ----------------------------------------------------------------------------
// pif_checker
// Port-level checks of the formatter, bound to the top level.
// ----------------------------------------------------------------------------
module pif_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] total_count,
  input logic        psel,
  input logic        pwrite,
  input logic [31:0] prdata
);

  logic        seen;
  logic [31:0] prev_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen       <= 1'b0;
      prev_count <= '0;
    end else if (out_valid && out_ready) begin
      seen       <= 1'b1;
      prev_count <= total_count;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen |-> total_count == prev_count + 32'd1)
    else $error("character count skipped or repeated");

  a_first_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !seen |-> total_count == 32'd1)
    else $error("first character after reset not counted as one");

  a_reg_bits: assert property (@(posedge clk) disable iff (rst)
    psel && !pwrite |-> prdata[31:1] == 31'd0)
    else $error("register read shows bits beyond its width");

endmodule

bind printf_integer_formatter pif_checker u_pif_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .total_count (out_ch.total_count),
  .psel        (psel),
  .pwrite      (pwrite),
  .prdata      (prdata)
);
